// ===== design/grpw_pkg.sv =====
package grpw_pkg;

  localparam int MAX_GLYPH_WIDTH = 24;
  localparam int QUEUE_DEPTH     = 2;
  localparam int ROW_BITS_W      = 24;
  localparam int PADDR_W         = 5;
  localparam int PDATA_W         = 32;
  localparam int LINE_START_W    = 28;
  localparam int PIX_IDX_W       = 29;

  // register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_TEXT_COLOR   = 3'd0,
    REG_BACK_COLOR   = 3'd1,
    REG_GLYPH_WIDTH  = 3'd2,
    REG_FRAME_BASE_0 = 3'd3,
    REG_FRAME_BASE_1 = 3'd4,
    REG_LINE_PIXELS  = 3'd5,
    REG_PIXEL_FORMAT = 3'd6
  } reg_idx_t;

  localparam logic [1:0] PIX_FMT_ARGB8888 = 2'd0;
  localparam logic [1:0] PIX_FMT_RGB888   = 2'd1;

  typedef enum logic [1:0] {
    SIZE_WORD = 2'd0,
    SIZE_RGB  = 2'd1,
    SIZE_HALF = 2'd2
  } wsize_t;

  localparam logic [31:0] TEXT_COLOR_RST   = 32'hFF00_0000;
  localparam logic [31:0] BACK_COLOR_RST   = 32'hFFFF_FFFF;
  localparam logic [4:0]  GLYPH_WIDTH_RST  = 5'd17;
  localparam logic [31:0] FRAME_BASE_0_RST = 32'hD200_0000;
  localparam logic [31:0] FRAME_BASE_1_RST = 32'hD217_7000;
  localparam logic [11:0] LINE_PIXELS_RST  = 12'd800;
  localparam logic [1:0]  PIXEL_FORMAT_RST = PIX_FMT_ARGB8888;

  typedef struct packed {
    logic [31:0] text_color;
    logic [31:0] back_color;
    logic [4:0]  glyph_width;
    logic [31:0] frame_base_0;
    logic [31:0] frame_base_1;
    logic [11:0] line_pixels;
    logic [1:0]  pixel_format;
  } cfg_t;

  // one classified glyph row, front to back
  typedef struct packed {
    logic [31:0]              base;
    logic [LINE_START_W-1:0]  line_start;
    logic [15:0]              x;
    logic [ROW_BITS_W-1:0]    bits;
    logic [4:0]               width;
    wsize_t                   size;
  } row_desc_t;

  // one pixel before address scaling
  typedef struct packed {
    logic [PIX_IDX_W-1:0] idx;
    logic [31:0]          color;
    logic [31:0]          base;
    wsize_t               size;
    logic                 last;
  } pix_t;

endpackage

// ===== design/grpw_ifs.sv =====
interface grpw_in_if;
  logic        valid;
  logic        ready;
  logic        layer_sel;
  logic [15:0] x_pos;
  logic [15:0] row_y;
  logic [23:0] row_bits;

  modport source (output valid, layer_sel, x_pos, row_y, row_bits, input ready);
  modport sink (input valid, layer_sel, x_pos, row_y, row_bits, output ready);
endinterface

interface grpw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] write_addr;
  logic [31:0] write_data;
  logic [1:0]  write_size;
  logic        last_pixel;

  modport source (output valid, write_addr, write_data, write_size, last_pixel, input ready);
  modport sink (input valid, write_addr, write_data, write_size, last_pixel, output ready);
endinterface

// ===== design/grpw_front.sv =====
module grpw_front (
  input  logic                 clk,
  input  logic                 rst,
  input  grpw_pkg::cfg_t       cfg,
  grpw_in_if.sink              row_in,
  output grpw_pkg::row_desc_t  desc,
  output logic                 desc_valid,
  input  logic                 desc_ready
);
  import grpw_pkg::*;

  logic [4:0]              width;
  logic [4:0]              width_p7;
  logic [1:0]              nbytes;
  logic [1:0]              pad_bytes;
  logic [ROW_BITS_W-1:0]   aligned;
  logic [LINE_START_W-1:0] line_start;
  wsize_t                  size;
  logic                    take;

  always_comb begin
    width = (cfg.glyph_width > 5'(MAX_GLYPH_WIDTH)) ? 5'(MAX_GLYPH_WIDTH) : cfg.glyph_width;
    width_p7 = width + 5'd7;
    nbytes = width_p7[4:3];
    pad_bytes = 2'd3 - nbytes;
    // move column zero to the top bit
    aligned = row_in.row_bits << {pad_bytes, 3'b000};
    line_start = {12'b0, row_in.row_y} * {16'b0, cfg.line_pixels};
    if (cfg.pixel_format == PIX_FMT_ARGB8888) begin
      size = SIZE_WORD;
    end else if (cfg.pixel_format == PIX_FMT_RGB888) begin
      size = SIZE_RGB;
    end else begin
      size = SIZE_HALF;
    end
  end

  assign row_in.ready = !desc_valid || desc_ready;
  assign take = row_in.valid && row_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
    end else if (row_in.ready) begin
      // drop zero-width rows here
      desc_valid <= row_in.valid && (width != 5'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      desc.base <= row_in.layer_sel ? cfg.frame_base_1 : cfg.frame_base_0;
      desc.line_start <= line_start;
      desc.x <= row_in.x_pos;
      desc.bits <= aligned;
      desc.width <= width;
      desc.size <= size;
    end
  end

endmodule

// ===== design/grpw_queue.sv =====
module grpw_queue #(
  parameter int DEPTH = grpw_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  grpw_pkg::row_desc_t  push_data,
  input  logic                 push_valid,
  output logic                 push_ready,
  output grpw_pkg::row_desc_t  pop_data,
  output logic                 pop_valid,
  input  logic                 pop_ready
);
  import grpw_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  row_desc_t            slots [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/grpw_back.sv =====
module grpw_back (
  input  logic                 clk,
  input  logic                 rst,
  input  grpw_pkg::cfg_t       cfg,
  input  grpw_pkg::row_desc_t  desc,
  input  logic                 desc_valid,
  output logic                 desc_ready,
  grpw_out_if.source           pix_out
);
  import grpw_pkg::*;

  logic                    busy;
  logic [31:0]             base;
  logic [LINE_START_W-1:0] line_start;
  logic [15:0]             col;
  logic [ROW_BITS_W-1:0]   bits;
  logic [4:0]              remain;
  wsize_t                  size;

  logic                    p_valid;
  pix_t                    pix;
  logic                    o_valid;
  logic [31:0]             o_addr;
  logic [31:0]             o_data;
  wsize_t                  o_size;
  logic                    o_last;

  logic                    adv_o;
  logic                    adv_p;
  logic                    emit;
  logic                    last_now;
  logic                    load;
  logic [31:0]             idx32;
  logic [31:0]             offset;
  logic [31:0]             data;

  assign adv_o = !o_valid || pix_out.ready;
  assign adv_p = !p_valid || adv_o;
  assign emit = busy && adv_p;
  assign last_now = (remain == 5'd1);
  assign desc_ready = !busy || (emit && last_now);
  assign load = desc_valid && desc_ready;

  always_comb begin
    idx32 = 32'(pix.idx);
    unique case (pix.size)
      SIZE_WORD: begin
        offset = idx32 << 2;
        data = pix.color;
      end
      SIZE_RGB: begin
        offset = idx32 + (idx32 << 1);
        data = {8'h00, pix.color[23:0]};
      end
      default: begin
        offset = idx32 << 1;
        data = {16'h0000, pix.color[15:0]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (emit && last_now) begin
        busy <= 1'b0;
      end
      if (adv_p) begin
        p_valid <= busy;
      end
      if (adv_o) begin
        o_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      base <= desc.base;
      line_start <= desc.line_start;
      col <= desc.x;
      bits <= desc.bits;
      remain <= desc.width;
      size <= desc.size;
    end else if (emit) begin
      col <= col + 16'd1;
      bits <= bits << 1;
      remain <= remain - 5'd1;
    end
    if (emit) begin
      pix.idx <= PIX_IDX_W'(line_start) + PIX_IDX_W'(col);
      pix.color <= bits[ROW_BITS_W-1] ? cfg.text_color : cfg.back_color;
      pix.base <= base;
      pix.size <= size;
      pix.last <= last_now;
    end
    if (adv_o && p_valid) begin
      o_addr <= pix.base + offset;
      o_data <= data;
      o_size <= pix.size;
      o_last <= pix.last;
    end
  end

  assign pix_out.valid = o_valid;
  assign pix_out.write_addr = o_addr;
  assign pix_out.write_data = o_data;
  assign pix_out.write_size = o_size;
  assign pix_out.last_pixel = o_last;

endmodule

// ===== design/glyph_row_pixel_writer_top.sv =====
// Throughput: one pixel write per cycle while pix_out.ready holds; a row makes
// glyph_width writes (capped at 24) from the single back-end column generator.
// Rows follow each other with no gap; a zero-width row produces no writes.
// Reset (rst, synchronous) empties the pipeline and queue and restores the
// register defaults.
module glyph_row_pixel_writer_top #(
  parameter int QUEUE_DEPTH = grpw_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [grpw_pkg::PADDR_W-1:0]  paddr,
  input  logic [grpw_pkg::PDATA_W-1:0]  pwdata,
  output logic [grpw_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  grpw_in_if.sink                       row_in,
  grpw_out_if.source                    pix_out
);
  import grpw_pkg::*;

  cfg_t      cfg;
  reg_idx_t  reg_idx;
  logic      wr_en;
  row_desc_t front_desc;
  logic      front_valid;
  logic      front_ready;
  row_desc_t queue_desc;
  logic      queue_valid;
  logic      queue_ready;

  assign pready = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_color <= TEXT_COLOR_RST;
      cfg.back_color <= BACK_COLOR_RST;
      cfg.glyph_width <= GLYPH_WIDTH_RST;
      cfg.frame_base_0 <= FRAME_BASE_0_RST;
      cfg.frame_base_1 <= FRAME_BASE_1_RST;
      cfg.line_pixels <= LINE_PIXELS_RST;
      cfg.pixel_format <= PIXEL_FORMAT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TEXT_COLOR:   cfg.text_color <= pwdata;
        REG_BACK_COLOR:   cfg.back_color <= pwdata;
        REG_GLYPH_WIDTH:  cfg.glyph_width <= pwdata[4:0];
        REG_FRAME_BASE_0: cfg.frame_base_0 <= pwdata;
        REG_FRAME_BASE_1: cfg.frame_base_1 <= pwdata;
        REG_LINE_PIXELS:  cfg.line_pixels <= pwdata[11:0];
        REG_PIXEL_FORMAT: cfg.pixel_format <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEXT_COLOR:   prdata = cfg.text_color;
      REG_BACK_COLOR:   prdata = cfg.back_color;
      REG_GLYPH_WIDTH:  prdata = {27'b0, cfg.glyph_width};
      REG_FRAME_BASE_0: prdata = cfg.frame_base_0;
      REG_FRAME_BASE_1: prdata = cfg.frame_base_1;
      REG_LINE_PIXELS:  prdata = {20'b0, cfg.line_pixels};
      REG_PIXEL_FORMAT: prdata = {30'b0, cfg.pixel_format};
      default:          prdata = '0;
    endcase
  end

  grpw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .row_in     (row_in),
    .desc       (front_desc),
    .desc_valid (front_valid),
    .desc_ready (front_ready)
  );

  grpw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (front_desc),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (queue_desc),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready)
  );

  grpw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .desc       (queue_desc),
    .desc_valid (queue_valid),
    .desc_ready (queue_ready),
    .pix_out    (pix_out)
  );

endmodule

// ===== design/grpw_checker.sv =====
module grpw_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] write_size,
  input logic       last_pixel
);
  import grpw_pkg::*;

  // hold a stalled write
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("write dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("write valid right after reset");

  // a row streams without gaps once started
  a_row_gapless: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_pixel |=> out_valid)
    else $error("gap inside a row");

  a_row_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_pixel |=> write_size == $past(write_size))
    else $error("write size changed inside a row");

  a_size_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> write_size != 2'd3)
    else $error("undefined write size");

endmodule

bind glyph_row_pixel_writer_top grpw_checker u_grpw_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (pix_out.valid),
  .out_ready  (pix_out.ready),
  .write_size (pix_out.write_size),
  .last_pixel (pix_out.last_pixel)
);
